>>> rtl/core/sfd_pkg.sv
// Package for the serial frame deframer: phase encoding, byte constants
// and the frame result structure. No dependencies.
package sfd_pkg;

    localparam int STORE_DEPTH = 9;
    localparam int IDX_W       = 4;
    localparam int BYTE_W      = 8;

    localparam logic [BYTE_W-1:0] MARKER_RESET = 8'h58;  // 'X'
    localparam logic [BYTE_W-1:0] DIGIT_ZERO   = 8'h30;  // '0'
    localparam logic [BYTE_W-1:0] DIGIT_NINE   = 8'h39;  // '9'

    localparam logic [IDX_W-1:0] STORE_LAST_IDX = IDX_W'(STORE_DEPTH);

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [STORE_DEPTH-1:0][BYTE_W-1:0] store_t;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CMD  = 3'd1,
        PH_LEN  = 3'd2,
        PH_PAY  = 3'd3,
        PH_TAIL = 3'd4
    } phase_t;

    typedef struct packed {
        byte_t  command;
        idx_t   payload_len;
        store_t payload;
    } frame_t;

endpackage

>>> rtl/core/sfd_parser.sv
// Frame parser state machine: phase, held command, payload store and counters.
// Depends on sfd_pkg.
module sfd_parser (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           byte_accept,
    input  sfd_pkg::byte_t rx_byte,
    input  sfd_pkg::byte_t frame_marker,
    output logic           frame_done,
    output sfd_pkg::frame_t frame
);
    import sfd_pkg::*;

    phase_t phase_reg, phase_next;
    byte_t  cmd_reg, cmd_next;
    store_t store_reg, store_next;
    idx_t   widx_reg, widx_next;
    idx_t   left_reg, left_next;
    idx_t   left_dec;
    logic   is_digit;

    assign is_digit = (rx_byte >= DIGIT_ZERO) && (rx_byte <= DIGIT_NINE);
    assign left_dec = (left_reg != '0) ? left_reg - idx_t'(1) : left_reg;

    // next state
    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        store_next = store_reg;
        widx_next  = widx_reg;
        left_next  = left_reg;
        if (byte_accept) begin
            case (phase_reg)
                PH_CMD: begin
                    cmd_next   = rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    if (is_digit) begin
                        // '0'..'9' map to their low nibble
                        left_next  = rx_byte[IDX_W-1:0];
                        widx_next  = '0;
                        phase_next = (rx_byte[IDX_W-1:0] == '0) ? PH_TAIL : PH_PAY;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_PAY: begin
                    if (widx_reg < STORE_LAST_IDX) begin
                        store_next[widx_reg] = rx_byte;
                        widx_next            = widx_reg + idx_t'(1);
                    end
                    left_next = left_dec;
                    if ((left_dec == '0) || (widx_next >= STORE_LAST_IDX)) begin
                        phase_next = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    if (rx_byte == frame_marker) begin
                        phase_next = PH_HUNT;
                    end
                end
                default: begin
                    phase_next = (rx_byte == frame_marker) ? PH_CMD : PH_HUNT;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        frame_done        = byte_accept && (phase_reg == PH_TAIL) && (rx_byte == frame_marker);
        frame.command     = cmd_reg;
        frame.payload_len = widx_reg;
        frame.payload     = store_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            cmd_reg   <= '0;
            store_reg <= '0;
            widx_reg  <= '0;
            left_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            store_reg <= store_next;
            widx_reg  <= widx_next;
            left_reg  <= left_next;
        end
    end

endmodule

>>> rtl/core/serial_frame_deframer.sv
// Serial frame deframer top level: marker register, parser and result register.
// Depends on sfd_pkg and sfd_parser.
//
// Usage:
//   s_ channel carries one received byte per beat (s_valid/s_ready).
//   m_ channel carries one decoded frame per beat: command, payload length
//   and all nine payload store bytes (bytes past the length keep older data).
//   A frame is marker, command, ASCII length digit, payload bytes, marker;
//   non-marker bytes after the payload are skipped.
//   cfg_wr_en/cfg_wr_data write the frame marker (reset value 'X'); write only
//   while idle.
// Throughput: one byte per cycle (single parser update) unless m_ready stalls.
// Latency: the frame beat is valid the cycle after the closing marker beat.
// Reset (aresetn low, synchronous): parser hunts for a marker, store and
//   counters clear, result register empties.
// Stall: while a frame waits and m_ready is low, s_ready is low; when the
//   frame is taken a new byte is accepted in the same cycle.
module serial_frame_deframer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  sfd_pkg::byte_t cfg_wr_data,
    input  logic           s_valid,
    output logic           s_ready,
    input  sfd_pkg::byte_t s_rx_byte,
    output logic           m_valid,
    input  logic           m_ready,
    output sfd_pkg::byte_t m_command,
    output sfd_pkg::idx_t  m_payload_len,
    output sfd_pkg::byte_t m_payload_0,
    output sfd_pkg::byte_t m_payload_1,
    output sfd_pkg::byte_t m_payload_2,
    output sfd_pkg::byte_t m_payload_3,
    output sfd_pkg::byte_t m_payload_4,
    output sfd_pkg::byte_t m_payload_5,
    output sfd_pkg::byte_t m_payload_6,
    output sfd_pkg::byte_t m_payload_7,
    output sfd_pkg::byte_t m_payload_8
);
    import sfd_pkg::*;

    byte_t  marker_reg;
    logic   out_valid_reg, out_valid_next;
    frame_t out_reg;
    logic   byte_accept;
    logic   frame_done;
    frame_t frame;

    assign s_ready     = !out_valid_reg || m_ready;
    assign byte_accept = s_valid && s_ready;

    sfd_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_accept  (byte_accept),
        .rx_byte      (s_rx_byte),
        .frame_marker (marker_reg),
        .frame_done   (frame_done),
        .frame        (frame)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (frame_done) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_reg    <= MARKER_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                marker_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (frame_done) begin
            out_reg <= frame;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_command     = out_reg.command;
    assign m_payload_len = out_reg.payload_len;
    assign m_payload_0   = out_reg.payload[0];
    assign m_payload_1   = out_reg.payload[1];
    assign m_payload_2   = out_reg.payload[2];
    assign m_payload_3   = out_reg.payload[3];
    assign m_payload_4   = out_reg.payload[4];
    assign m_payload_5   = out_reg.payload[5];
    assign m_payload_6   = out_reg.payload[6];
    assign m_payload_7   = out_reg.payload[7];
    assign m_payload_8   = out_reg.payload[8];

endmodule

>>> tb/testbench.sv
// Self-checking testbench for serial_frame_deframer: byte beats in, frame beats out,
// each frame checked against an in-bench frame parser. Depends on sfd_pkg and the
// serial_frame_deframer RTL.
`timescale 1ns / 1ps

module testbench;
    import sfd_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 7;
    localparam int IDLE_PCT     = 18;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_WAIT  = 4;

    logic   aclk        = 1'b0;
    logic   aresetn     = 1'b0;
    logic   cfg_wr_en   = 1'b0;
    byte_t  cfg_wr_data = '0;
    logic   s_valid     = 1'b0;
    logic   s_ready;
    byte_t  s_rx_byte   = '0;
    logic   m_valid;
    logic   m_ready     = 1'b0;
    byte_t  m_command;
    idx_t   m_payload_len;
    byte_t  m_payload_0, m_payload_1, m_payload_2, m_payload_3, m_payload_4;
    byte_t  m_payload_5, m_payload_6, m_payload_7, m_payload_8;

    serial_frame_deframer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_command     (m_command),
        .m_payload_len (m_payload_len),
        .m_payload_0   (m_payload_0),
        .m_payload_1   (m_payload_1),
        .m_payload_2   (m_payload_2),
        .m_payload_3   (m_payload_3),
        .m_payload_4   (m_payload_4),
        .m_payload_5   (m_payload_5),
        .m_payload_6   (m_payload_6),
        .m_payload_7   (m_payload_7),
        .m_payload_8   (m_payload_8)
    );

    always #HALF_PERIOD aclk = ~aclk;

    byte_t  rx_pending [$];
    frame_t frames_due [$];
    int     fails = 0;
    bit     calm = 1'b0;
    bit     hold_go = 1'b0;
    bit     hold_seen = 1'b0;
    int     hold_left = 0;
    int     quiet_cycles = 0;

    // parser shadow state
    byte_t  marker_q = MARKER_RESET;
    phase_t ph = PH_HUNT;
    byte_t  cmd_q = '0;
    store_t store_q = '0;
    idx_t   wr_idx = '0;
    idx_t   left_q = '0;

    task automatic parse_byte(input byte_t b);
        frame_t f;
        case (ph)
            PH_CMD: begin
                cmd_q = b;
                ph = PH_LEN;
            end
            PH_LEN: begin
                if (b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
                    left_q = idx_t'(b - DIGIT_ZERO);
                    wr_idx = '0;
                    ph = (left_q == '0) ? PH_TAIL : PH_PAY;
                end else begin
                    ph = PH_HUNT;
                end
            end
            PH_PAY: begin
                if (wr_idx < STORE_LAST_IDX) begin
                    store_q[wr_idx] = b;
                    wr_idx = wr_idx + 1'b1;
                end
                if (left_q != '0) left_q = left_q - 1'b1;
                if (left_q == '0 || wr_idx >= STORE_LAST_IDX) ph = PH_TAIL;
            end
            PH_TAIL: begin
                if (b == marker_q) begin
                    ph = PH_HUNT;
                    f.command     = cmd_q;
                    f.payload_len = wr_idx;
                    f.payload     = store_q;
                    frames_due.push_back(f);
                end
            end
            default: ph = (b == marker_q) ? PH_CMD : PH_HUNT;
        endcase
    endtask

    // byte driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) parse_byte(s_rx_byte);
            if (!s_valid || s_ready) begin
                if (rx_pending.size() > 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= rx_pending.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // frame monitor
    store_t got_pay;
    frame_t want;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_pay = {m_payload_8, m_payload_7, m_payload_6, m_payload_5, m_payload_4,
                       m_payload_3, m_payload_2, m_payload_1, m_payload_0};
            if (frames_due.size() == 0) begin
                $error("frame beat with no frame due");
                fails++;
            end else begin
                want = frames_due.pop_front();
                if (m_command !== want.command) begin
                    $error("command: expected %0h, got %0h", want.command, m_command);
                    fails++;
                end
                if (m_payload_len !== want.payload_len) begin
                    $error("payload_len: expected %0d, got %0d",
                           want.payload_len, m_payload_len);
                    fails++;
                end
                for (int i = 0; i < STORE_DEPTH; i++) begin
                    if (got_pay[i] !== want.payload[i]) begin
                        $error("payload_%0d: expected %0h, got %0h",
                               i, want.payload[i], got_pay[i]);
                        fails++;
                    end
                end
            end
        end
        if (hold_go != hold_seen) begin
            hold_seen = hold_go;
            hold_left = HOLD_CYCLES;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic drain();
        @(negedge aclk);
        while (rx_pending.size() > 0 || s_valid || frames_due.size() > 0)
            @(negedge aclk);
    endtask

    task automatic write_marker(input byte_t v);
        drain();
        repeat (SETTLE_WAIT) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        marker_q = v;
        @(negedge aclk);
    endtask

    function automatic byte_t rand_byte();
        return byte_t'($urandom_range(0, 255));
    endfunction

    function automatic byte_t non_digit();
        byte_t b;
        b = rand_byte();
        while (b >= DIGIT_ZERO && b <= DIGIT_NINE) b = rand_byte();
        return b;
    endfunction

    task automatic push_frame(input byte_t cmd, input int len, input int noise,
                              output int n);
        rx_pending.push_back(marker_q);
        rx_pending.push_back(cmd);
        rx_pending.push_back(byte_t'(DIGIT_ZERO + len));
        for (int i = 0; i < len; i++) rx_pending.push_back(rand_byte());
        for (int i = 0; i < noise; i++) rx_pending.push_back(rand_byte());
        rx_pending.push_back(marker_q);
        n = len + noise + 4;
    endtask

    task automatic queue_random(input int target);
        int sent;
        int n;
        int kind;
        byte_t cmd;
        sent = 0;
        while (sent < target) begin
            kind = $urandom_range(0, 99);
            cmd  = ($urandom_range(0, 4) == 0) ? marker_q : rand_byte();
            if (kind < 75) begin
                push_frame(cmd, $urandom_range(0, 9),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, n);
                sent += n;
            end else if (kind < 85) begin
                rx_pending.push_back(marker_q);
                rx_pending.push_back(cmd);
                rx_pending.push_back(non_digit());
                sent += 3;
            end else if (kind < 92) begin
                n = $urandom_range(1, 9);
                rx_pending.push_back(marker_q);
                rx_pending.push_back(cmd);
                rx_pending.push_back(byte_t'(DIGIT_ZERO + n));
                n = $urandom_range(0, n - 1);
                for (int i = 0; i < n; i++) rx_pending.push_back(rand_byte());
                sent += n + 3;
            end else begin
                n = $urandom_range(1, 3);
                repeat (n) rx_pending.push_back(rand_byte());
                sent += n;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // full-length frame, marker as command, extreme payload bytes
        rx_pending.push_back(marker_q);
        rx_pending.push_back(marker_q);
        rx_pending.push_back(DIGIT_NINE);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hAA);
        rx_pending.push_back(8'h55);
        rx_pending.push_back(8'h01);
        rx_pending.push_back(8'h80);
        rx_pending.push_back(8'h7F);
        rx_pending.push_back(8'hFE);
        rx_pending.push_back(8'h0F);
        rx_pending.push_back(marker_q);
        // bad length bytes either side of the digit range
        rx_pending.push_back(marker_q);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(DIGIT_ZERO - 1'b1);
        rx_pending.push_back(marker_q);
        rx_pending.push_back(8'h41);
        rx_pending.push_back(DIGIT_NINE + 1'b1);
        // tail noise after a one-byte payload
        rx_pending.push_back(marker_q);
        rx_pending.push_back(8'h7F);
        rx_pending.push_back(DIGIT_ZERO + 1'b1);
        rx_pending.push_back(8'h80);
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(marker_q);
        // zero length left open across a marker change
        rx_pending.push_back(marker_q);
        rx_pending.push_back(8'h00);
        rx_pending.push_back(DIGIT_ZERO);

        write_marker(8'h00);
        rx_pending.push_back(marker_q);
        queue_random(470);
        hold_go = ~hold_go;

        write_marker(8'hFF);
        calm = 1'b1;
        queue_random(470);
        drain();
        calm = 1'b0;

        write_marker(rand_byte());
        queue_random(235);
        drain();
        queue_random(235);

        write_marker(MARKER_RESET);
        queue_random(470);

        drain();
        repeat (SETTLE_WAIT * 4) @(posedge aclk);
        @(negedge aclk);
        if (fails == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/sfd_pkg.sv
rtl/core/sfd_parser.sv
rtl/core/serial_frame_deframer.sv
tb/testbench.sv
